@@ rtl/core/oli_pkg.sv @@
// Shared types, codes and defaults for the ordered list block.
`timescale 1ns / 1ps

package oli_pkg;

    // Default sizes of the list storage.
    localparam int DEPTH_DEF      = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed widths of the request and result fields.
    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 5;
    localparam int LENGTH_W = 6;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [1:0]          t_rd_sel;

    // Request codes.
    localparam t_func FUNC_APPEND = 2'd0;
    localparam t_func FUNC_INSERT = 2'd1;
    localparam t_func FUNC_READ   = 2'd2;
    localparam t_func FUNC_REMOVE = 2'd3;

    // Result status codes.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    // Storage read address selection.
    localparam t_rd_sel RA_IDX   = 2'd0;
    localparam t_rd_sel RA_BELOW = 2'd1;
    localparam t_rd_sel RA_ABOVE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    latch_status;
        logic    ram_re;
        t_rd_sel rd_sel;
        logic    ram_we;
        logic    wr_at_count;
        logic    wr_value;
        logic    load_p_count;
        logic    load_p_idx;
        logic    p_dec;
        logic    p_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cap_rd;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func   func;
        t_status status;
        logic    full;
        logic    empty;
        logic    p_at_idx;
        logic    p_last;
        logic    out_free;
    } t_sts;

endpackage

@@ rtl/core/oli_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module oli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/oli_ctrl.sv @@
// Controller state machine that sequences list requests.
`timescale 1ns / 1ps

module oli_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  oli_pkg::t_sts i_sts,
    output oli_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_FETCH   = 4'd2;
    localparam logic [3:0] S_CAPTURE = 4'd3;
    localparam logic [3:0] S_UP_RD   = 4'd4;
    localparam logic [3:0] S_UP_WR   = 4'd5;
    localparam logic [3:0] S_DN_RD   = 4'd6;
    localparam logic [3:0] S_DN_WR   = 4'd7;
    localparam logic [3:0] S_FINISH  = 4'd8;

    logic [3:0]    r_state;
    logic [3:0]    n_state;
    oli_pkg::t_cmd cmd;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.latch_status = 1'b1;
                if (i_sts.status != oli_pkg::ST_OK) begin
                    n_state = S_FINISH;
                end else if (i_sts.func == oli_pkg::FUNC_APPEND) begin
                    cmd.ram_we      = 1'b1;
                    cmd.wr_at_count = 1'b1;
                    cmd.wr_value    = 1'b1;
                    cmd.cnt_inc     = 1'b1;
                    n_state         = S_FINISH;
                end else if (i_sts.func == oli_pkg::FUNC_INSERT) begin
                    cmd.load_p_count = 1'b1;
                    n_state          = S_UP_RD;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                cmd.ram_re = 1'b1;
                cmd.rd_sel = oli_pkg::RA_IDX;
                n_state    = S_CAPTURE;
            end
            S_CAPTURE: begin
                cmd.cap_rd = 1'b1;
                if (i_sts.func == oli_pkg::FUNC_READ) begin
                    n_state = S_FINISH;
                end else begin
                    cmd.load_p_idx = 1'b1;
                    n_state        = S_DN_RD;
                end
            end
            // Move entries up one place, starting from the end.
            S_UP_RD: begin
                if (i_sts.p_at_idx) begin
                    cmd.ram_we   = 1'b1;
                    cmd.wr_value = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    cmd.ram_re = 1'b1;
                    cmd.rd_sel = oli_pkg::RA_BELOW;
                    n_state    = S_UP_WR;
                end
            end
            S_UP_WR: begin
                cmd.ram_we = 1'b1;
                cmd.p_dec  = 1'b1;
                n_state    = S_UP_RD;
            end
            // Move entries down one place, starting at the removed slot.
            S_DN_RD: begin
                if (i_sts.p_last) begin
                    cmd.cnt_dec = 1'b1;
                    n_state     = S_FINISH;
                end else begin
                    cmd.ram_re = 1'b1;
                    cmd.rd_sel = oli_pkg::RA_ABOVE;
                    n_state    = S_DN_WR;
                end
            end
            S_DN_WR: begin
                cmd.ram_we = 1'b1;
                cmd.p_inc  = 1'b1;
                n_state    = S_DN_RD;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);

endmodule

@@ rtl/core/oli_dp.sv @@
// Datapath: request registers, list storage, length counter and result register.
`timescale 1ns / 1ps

module oli_dp #(
    parameter int DEPTH      = oli_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = oli_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  oli_pkg::t_cmd                 i_cmd,
    output oli_pkg::t_sts                 o_sts,
    input  logic [oli_pkg::FUNC_W-1:0]    i_func,
    input  logic [oli_pkg::VALUE_W-1:0]   i_value,
    input  logic [oli_pkg::INDEX_W-1:0]   i_index,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [oli_pkg::VALUE_W-1:0]   o_read_value,
    output logic [oli_pkg::LENGTH_W-1:0]  o_length,
    output logic [oli_pkg::STATUS_W-1:0]  o_status
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CW1 = CW + 1;
    localparam int IW  = (CW > oli_pkg::INDEX_W) ? CW : oli_pkg::INDEX_W;

    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  r_p;
    oli_pkg::t_func                 r_func;
    logic [VALUE_BITS-1:0]          r_value;
    logic [oli_pkg::INDEX_W-1:0]    r_idx;
    oli_pkg::t_status               r_status;
    logic [oli_pkg::VALUE_W-1:0]    r_rd;
    logic                           r_out_valid;
    logic [oli_pkg::VALUE_W-1:0]    r_out_rd;
    logic [oli_pkg::LENGTH_W-1:0]   r_out_len;
    oli_pkg::t_status               r_out_status;

    logic                  full;
    logic                  idx_gt;
    logic                  idx_ge;
    oli_pkg::t_status      status;
    logic [AW-1:0]         ram_raddr;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;
    logic [VALUE_BITS-1:0] ram_rdata;

    // Control registers: entry count and result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, working pointer and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func  <= i_func;
            r_value <= VALUE_BITS'(i_value);
            r_idx   <= i_index;
            r_rd    <= '0;
        end else if (i_cmd.cap_rd) begin
            r_rd <= oli_pkg::VALUE_W'(ram_rdata);
        end
        if (i_cmd.latch_status) begin
            r_status <= status;
        end
        if (i_cmd.load_p_count) begin
            r_p <= r_count;
        end else if (i_cmd.load_p_idx) begin
            r_p <= CW'(r_idx);
        end else if (i_cmd.p_dec) begin
            r_p <= r_p - 1'b1;
        end else if (i_cmd.p_inc) begin
            r_p <= r_p + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_rd     <= r_rd;
            r_out_len    <= oli_pkg::LENGTH_W'(r_count);
            r_out_status <= r_status;
        end
    end

    // Request checks against the current length.
    always_comb begin
        full   = (r_count == CW'(DEPTH));
        idx_gt = (IW'(r_idx) > IW'(r_count));
        idx_ge = (IW'(r_idx) >= IW'(r_count));
        case (r_func)
            oli_pkg::FUNC_APPEND: status = full ? oli_pkg::ST_FULL : oli_pkg::ST_OK;
            oli_pkg::FUNC_INSERT: begin
                if (full) begin
                    status = oli_pkg::ST_FULL;
                end else if (idx_gt) begin
                    status = oli_pkg::ST_RANGE;
                end else begin
                    status = oli_pkg::ST_OK;
                end
            end
            default: status = idx_ge ? oli_pkg::ST_RANGE : oli_pkg::ST_OK;
        endcase
    end

    // Storage address and data selection.
    always_comb begin
        case (i_cmd.rd_sel)
            oli_pkg::RA_IDX:   ram_raddr = AW'(r_idx);
            oli_pkg::RA_BELOW: ram_raddr = AW'(r_p - 1'b1);
            oli_pkg::RA_ABOVE: ram_raddr = AW'(r_p + 1'b1);
            default:           ram_raddr = AW'(r_idx);
        endcase
        ram_waddr = i_cmd.wr_at_count ? AW'(r_count) : AW'(r_p);
        ram_wdata = i_cmd.wr_value ? r_value : ram_rdata;
    end

    oli_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Status back to the controller.
    always_comb begin
        o_sts          = '0;
        o_sts.func     = r_func;
        o_sts.status   = status;
        o_sts.full     = full;
        o_sts.empty    = (r_count == '0);
        o_sts.p_at_idx = (IW'(r_p) == IW'(r_idx));
        o_sts.p_last   = ((CW1'(r_p) + 1'b1) >= CW1'(r_count));
        o_sts.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_length     = r_out_len;
    assign o_status     = r_out_status;

endmodule

@@ rtl/core/ordered_list_insert_remove.sv @@
// Top level of the fixed-capacity ordered list with insert and remove.
//
//  Channel   Direction  Handshake          Fields
//  request   in         i_valid / o_stall  i_func, i_value, i_index
//  result    out        o_valid / i_stall  o_read_value, o_length, o_status
//
// One request is in flight at a time; the controller returns to idle before the next beat.
// Shifting goes through the storage RAM, one read and then one write per entry.
// Synchronous active-low reset clears the length to zero; storage is not cleared.
// A stalled result holds in the output register; the next request beat is still taken.
`timescale 1ns / 1ps

module ordered_list_insert_remove #(
    parameter int DEPTH      = oli_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = oli_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [oli_pkg::FUNC_W-1:0]    i_func,
    input  logic [oli_pkg::VALUE_W-1:0]   i_value,
    input  logic [oli_pkg::INDEX_W-1:0]   i_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [oli_pkg::VALUE_W-1:0]   o_read_value,
    output logic [oli_pkg::LENGTH_W-1:0]  o_length,
    output logic [oli_pkg::STATUS_W-1:0]  o_status
);

    oli_pkg::t_cmd cmd;
    oli_pkg::t_sts sts;

    oli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    oli_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_index      (i_index),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_length     (o_length),
        .o_status     (o_status)
    );

    // The list never grows past capacity.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) cmd.cnt_inc |-> !sts.full)
        else $error("length incremented on a full list");

    // The list never shrinks below empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) cmd.cnt_dec |-> !sts.empty)
        else $error("length decremented on an empty list");

    // A new result never overwrites one that is still stalled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || !i_stall))
        else $error("result register overwritten while stalled");

    // After a request beat the block is busy until that request finishes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while another is in flight");

endmodule

@@ tb/sv/ordered_list_insert_remove_tb.sv @@
// Self-checking testbench for the fixed-capacity ordered list with insert and remove.
`timescale 1ns / 1ps

module ordered_list_insert_remove_tb;

    import oli_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int VALUE_BITS   = VALUE_BITS_DEF;
    localparam int RANDOM_BEATS = 1400;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_PRINTS   = 40;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [LENGTH_W-1:0] length;
        t_status             status;
    } list_result_t;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct {
        t_func              func;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        int                 reps;
        bit                 typed;
        list_result_t       res;
    } stim_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [FUNC_W-1:0]   i_func = '0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic [INDEX_W-1:0]  i_index = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [VALUE_W-1:0]  o_read_value;
    logic [LENGTH_W-1:0] o_length;
    logic [STATUS_W-1:0] o_status;

    // Shadow copy of the list contents and length.
    logic [VALUE_BITS-1:0] list_mem [LIST_DEPTH];
    int                    list_len = 0;

    list_result_t pending_results [$];
    stim_row_t    dir_rows [$];

    int n_errors   = 0;
    int n_results  = 0;
    int n_accepted = 0;
    int n_full     = 0;
    int n_range    = 0;
    int peak_len   = 0;
    int n_func [4] = '{0, 0, 0, 0};
    bit tx_calm    = 1'b0;
    bit rx_held    = 1'b0;
    int hold_left  = 0;

    ordered_list_insert_remove DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_index      (i_index),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_value (o_read_value),
        .o_length     (o_length),
        .o_status     (o_status)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(string msg);
        if (n_errors < MAX_PRINTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        n_errors++;
    endtask

    // Applies one request to the shadow list and returns the result it should give.
    function automatic list_result_t apply_list_request(t_func func,
                                                        logic [VALUE_W-1:0] value,
                                                        logic [INDEX_W-1:0] index);
        list_result_t res;
        int           idx;
        int           pos;
        res = '0;
        res.status = ST_OK;
        idx = int'(index);
        case (func)
            FUNC_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_mem[list_len] = value[VALUE_BITS-1:0];
                    list_len++;
                end
            end
            FUNC_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else if (idx > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (pos = list_len; pos > idx; pos--) begin
                        list_mem[pos] = list_mem[pos-1];
                    end
                    list_mem[idx] = value[VALUE_BITS-1:0];
                    list_len++;
                end
            end
            FUNC_READ: begin
                if (idx >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = list_mem[idx];
                end
            end
            default: begin
                if (idx >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = list_mem[idx];
                    for (pos = idx; pos + 1 < list_len; pos++) begin
                        list_mem[pos] = list_mem[pos+1];
                    end
                    list_len--;
                end
            end
        endcase
        res.length = list_len[LENGTH_W-1:0];
        return res;
    endfunction

    // Offers one request beat, after a random gap outside the calm stretch, and queues its expected result.
    task automatic send_request(t_func func, logic [VALUE_W-1:0] value,
                                logic [INDEX_W-1:0] index, bit typed, list_result_t typed_res);
        list_result_t res;
        while (!tx_calm && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_value <= value;
        i_index <= index;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        res = apply_list_request(func, value, index);
        pending_results.push_back(typed ? typed_res : res);
        n_accepted++;
        n_func[func]++;
        if (res.status == ST_FULL) n_full++;
        if (res.status == ST_RANGE) n_range++;
        if (list_len > peak_len) peak_len = list_len;
    endtask

    task automatic add_row(t_func func, logic [VALUE_W-1:0] value, logic [INDEX_W-1:0] index,
                           int reps, bit typed, logic [VALUE_W-1:0] rd,
                           logic [LENGTH_W-1:0] len, t_status st);
        stim_row_t row;
        row.func  = func;
        row.value = value;
        row.index = index;
        row.reps  = reps;
        row.typed = typed;
        row.res   = '{read_value: rd, length: len, status: st};
        dir_rows.push_back(row);
    endtask

    // Receiver: random stalls, one long hold-off, and a calm stretch.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!rx_held && n_results >= 200) begin
            rx_held   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (n_results >= 550 && n_results < 850) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 13);
        end
    end

    // Result checker: each accepted beat against the oldest expectation.
    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: %h %0d %0d",
                                          o_read_value, o_length, o_status));
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    report_mismatch($sformatf("result %0d read_value %h, expected %h",
                                              n_results, o_read_value, want.read_value));
                end
                if (o_length !== want.length) begin
                    report_mismatch($sformatf("result %0d length %0d, expected %0d",
                                              n_results, o_length, want.length));
                end
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              n_results, o_status, want.status));
                end
            end
            n_results <= n_results + 1;
        end
    end

    // Stimulus: reset, directed table, then random requests.
    initial begin
        stim_row_t          row;
        t_func              func;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        bit                 filling;
        int                 pick;
        int                 n;
        int                 rep;

        // Empty list, range errors, first entries and insert at the tail.
        add_row(FUNC_READ,   32'h0,        5'd0,  1, 1'b1, 32'h0,        6'd0,  ST_RANGE);
        add_row(FUNC_REMOVE, 32'h0,        5'd0,  1, 1'b1, 32'h0,        6'd0,  ST_RANGE);
        add_row(FUNC_INSERT, 32'h1234_5678, 5'd1, 1, 1'b1, 32'h0,        6'd0,  ST_RANGE);
        add_row(FUNC_INSERT, 32'hFFFF_FFFF, 5'd0, 1, 1'b1, 32'h0,        6'd1,  ST_OK);
        add_row(FUNC_APPEND, 32'h0,        5'd31, 1, 1'b1, 32'h0,        6'd2,  ST_OK);
        add_row(FUNC_INSERT, 32'hA5A5_A5A5, 5'd2, 1, 1'b1, 32'h0,        6'd3,  ST_OK);
        add_row(FUNC_READ,   32'h0,        5'd0,  1, 1'b1, 32'hFFFF_FFFF, 6'd3, ST_OK);
        add_row(FUNC_READ,   32'h0,        5'd2,  1, 1'b1, 32'hA5A5_A5A5, 6'd3, ST_OK);
        add_row(FUNC_READ,   32'h0,        5'd3,  1, 1'b1, 32'h0,        6'd3,  ST_RANGE);
        add_row(FUNC_INSERT, 32'h5A5A_5A5A, 5'd1, 1, 1'b0, 32'h0,        6'd0,  ST_OK);
        add_row(FUNC_INSERT, 32'h0,        5'd5,  1, 1'b1, 32'h0,        6'd4,  ST_RANGE);
        add_row(FUNC_REMOVE, 32'h0,        5'd0,  1, 1'b1, 32'hFFFF_FFFF, 6'd3, ST_OK);
        add_row(FUNC_REMOVE, 32'h0,        5'd31, 1, 1'b1, 32'h0,        6'd3,  ST_RANGE);
        // Fill to capacity, then every request kind against a full list.
        add_row(FUNC_APPEND, 32'h8000_0000, 5'd0, 29, 1'b0, 32'h0,       6'd0,  ST_OK);
        add_row(FUNC_APPEND, 32'h1234_5678, 5'd0, 1, 1'b1, 32'h0,        6'd32, ST_FULL);
        add_row(FUNC_INSERT, 32'h1234_5678, 5'd31, 1, 1'b1, 32'h0,       6'd32, ST_FULL);
        add_row(FUNC_INSERT, 32'h1234_5678, 5'd0, 1, 1'b1, 32'h0,        6'd32, ST_FULL);
        add_row(FUNC_READ,   32'h0,        5'd31, 1, 1'b0, 32'h0,        6'd0,  ST_OK);
        add_row(FUNC_REMOVE, 32'h0,        5'd31, 1, 1'b0, 32'h0,        6'd0,  ST_OK);
        add_row(FUNC_INSERT, 32'h0F0F_0F0F, 5'd31, 1, 1'b0, 32'h0,       6'd0,  ST_OK);
        add_row(FUNC_REMOVE, 32'h0,        5'd0,  1, 1'b0, 32'h0,        6'd0,  ST_OK);
        add_row(FUNC_INSERT, 32'h0000_0001, 5'd0, 1, 1'b0, 32'h0,        6'd0,  ST_OK);
        add_row(FUNC_READ,   32'h0,        5'd0,  1, 1'b0, 32'h0,        6'd0,  ST_OK);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            for (rep = 0; rep < row.reps; rep++) begin
                send_request(row.func, row.value + rep, row.index, row.typed, row.res);
            end
        end

        // Random part: the list drifts between filling and draining so that
        // every length, including empty and full, is visited many times.
        filling = 1'b0;
        for (n = 0; n < RANDOM_BEATS; n++) begin
            tx_calm = (n >= 500 && n < 800);
            if (list_len == LIST_DEPTH && $urandom_range(0, 3) == 0) begin
                filling = 1'b0;
            end else if (list_len == 0 && $urandom_range(0, 3) == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                filling = !filling;
            end

            if ($urandom_range(0, 9) == 0) begin
                // Noise: any request kind at any index.
                func  = t_func'($urandom_range(0, 3));
                index = INDEX_W'($urandom_range(0, 31));
            end else begin
                pick = $urandom_range(0, 99);
                if (filling) begin
                    func = (pick < 35) ? FUNC_APPEND : (pick < 70) ? FUNC_INSERT :
                           (pick < 85) ? FUNC_READ : FUNC_REMOVE;
                end else begin
                    func = (pick < 15) ? FUNC_APPEND : (pick < 30) ? FUNC_INSERT :
                           (pick < 60) ? FUNC_READ : FUNC_REMOVE;
                end
                if (func == FUNC_INSERT) begin
                    index = INDEX_W'($urandom_range(0, (list_len < 31) ? list_len : 31));
                end else if (list_len > 0) begin
                    index = INDEX_W'($urandom_range(0, list_len - 1));
                end else begin
                    index = INDEX_W'($urandom_range(0, 31));
                end
            end

            pick = $urandom_range(0, 9);
            value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
            send_request(func, value, index, 1'b0, '0);
        end
        tx_calm = 1'b0;
        i_valid <= 1'b0;

        // Let every expected beat arrive, then watch for stray ones.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (append %0d, insert %0d, read %0d, remove %0d).",
                 n_accepted, n_func[FUNC_APPEND], n_func[FUNC_INSERT],
                 n_func[FUNC_READ], n_func[FUNC_REMOVE]);
        $display("Full rejections %0d, index rejections %0d, peak length %0d, %0d errors.",
                 n_full, n_range, peak_len, n_errors);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
